[hw/rtl/cfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants shared by the command frame deframer and its channels.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned LEN_W      = 11;
	localparam int unsigned POS_W      = LEN_W + 1;
	localparam int unsigned CNT_W      = 3;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [WORD_W-1:0] SYNC_WORD    = 32'h5555_5555;
	localparam logic [LEN_W-1:0]  HEADER_BYTES = 11'd12;
	localparam logic [POS_W-1:0]  SYNC_BYTES   = 12'd4;
	localparam logic [CNT_W-1:0]  FIELD_LAST   = 3'd3;

	localparam logic [BYTE_W-1:0] BYTE_TYPE_RESET = 8'd1;
	localparam logic [BYTE_W-1:0] WORD_TYPE_RESET = 8'd2;
	localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BYTE_TYPE = 2'd0,
		CFG_WORD_TYPE = 2'd1,
		CFG_MAX_LEN   = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_SEQ  = 3'd2,
		PH_CMD  = 3'd3,
		PH_TYPE = 3'd4,
		PH_DATA = 3'd5
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SUBFRAME   = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_BAD_LENGTH = 2'd2,
		ST_BAD_TYPE   = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   command;
		logic [BYTE_W-1:0]   sub_type;
		logic [WORD_W-1:0]   payload;
		logic [WORD_W-1:0]   sequence_res;
		logic                last_in_frame;
	} result_t;

endpackage

[hw/rtl/cfd_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd channels
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface cfd_byte_if;
	logic                        valid;
	logic                        ready;
	logic [cfd_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_result_if;
	logic                          valid;
	logic                          ready;
	logic [cfd_pkg::STATUS_W-1:0]  status;
	logic [cfd_pkg::BYTE_W-1:0]    command;
	logic [cfd_pkg::BYTE_W-1:0]    sub_type;
	logic [cfd_pkg::WORD_W-1:0]    payload;
	logic [cfd_pkg::WORD_W-1:0]    sequence_res;
	logic                          last_in_frame;

	modport source (output valid, output status, output command, output sub_type,
		output payload, output sequence_res, output last_in_frame, input ready);
	modport sink   (input valid, input status, input command, input sub_type,
		input payload, input sequence_res, input last_in_frame, output ready);
endinterface

[hw/rtl/command_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_deframer
// Sync hunt, header parse and sub-frame extraction for a command byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle, sustained, as long as results
// are taken. Each byte passes an input register, then a state update that
// builds the result in an output register; a result is offered from that
// output register once the byte that completes it leaves the input register.
// The input stalls whenever a result waits untaken and the input register
// already holds a byte. Configuration writes take effect on the next byte.
module command_frame_deframer #(
	parameter int unsigned LENGTH_LIMIT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	cfd_byte_if.sink                        rx,
	cfd_result_if.source                    res
);

	logic [cfd_pkg::BYTE_W-1:0]  byte_type_q;
	logic [cfd_pkg::BYTE_W-1:0]  word_type_q;
	logic [cfd_pkg::LEN_W-1:0]   max_len_q;

	logic                        valid_s1;
	logic [cfd_pkg::BYTE_W-1:0]  byte_s1;
	logic                        adv;

	cfd_pkg::phase_t             phase_q, phase_d;
	logic [cfd_pkg::WORD_W-1:0]  shift_q, shift_d;
	logic [cfd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [cfd_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [cfd_pkg::LEN_W-1:0]   flen_q, flen_d;
	logic [cfd_pkg::WORD_W-1:0]  seq_q, seq_d;
	logic [cfd_pkg::BYTE_W-1:0]  cmd_q, cmd_d;
	logic [cfd_pkg::BYTE_W-1:0]  type_q, type_d;

	logic                        res_valid_q;
	cfd_pkg::result_t            res_q;
	logic                        nres_valid;
	cfd_pkg::result_t            nres;

	logic [cfd_pkg::WORD_W-1:0]  word;
	logic [cfd_pkg::POS_W-1:0]   pos_inc;
	logic                        bad_len;
	logic                        done;
	logic                        last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_type_q <= cfd_pkg::BYTE_TYPE_RESET;
			word_type_q <= cfd_pkg::WORD_TYPE_RESET;
			max_len_q   <= cfd_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				cfd_pkg::CFG_BYTE_TYPE: byte_type_q <= cfg_wdata[cfd_pkg::BYTE_W-1:0];
				cfd_pkg::CFG_WORD_TYPE: word_type_q <= cfg_wdata[cfd_pkg::BYTE_W-1:0];
				cfd_pkg::CFG_MAX_LEN:   max_len_q   <= cfg_wdata[cfd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
			byte_s1  <= rx.rx_byte;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign word    = {shift_q[cfd_pkg::WORD_W-cfd_pkg::BYTE_W-1:0], byte_s1};
	assign pos_inc = pos_q + 1'b1;
	assign bad_len = (word < 32'(cfd_pkg::HEADER_BYTES)) || (word > 32'(max_len_q))
		|| (word > 32'(LENGTH_LIMIT));
	assign done    = (type_q == byte_type_q) || (cnt_q >= cfd_pkg::FIELD_LAST);
	assign last    = pos_inc >= {1'b0, flen_q};

	always_comb begin
		phase_d    = phase_q;
		shift_d    = shift_q;
		cnt_d      = cnt_q;
		pos_d      = pos_q;
		flen_d     = flen_q;
		seq_d      = seq_q;
		cmd_d      = cmd_q;
		type_d     = type_q;
		nres_valid = 1'b0;
		nres       = '0;
		case (phase_q)
			cfd_pkg::PH_HUNT: begin
				shift_d = word;
				if (word == cfd_pkg::SYNC_WORD) begin
					phase_d = cfd_pkg::PH_LEN;
					shift_d = '0;
					cnt_d   = '0;
					pos_d   = cfd_pkg::SYNC_BYTES;
				end
			end
			cfd_pkg::PH_LEN, cfd_pkg::PH_SEQ: begin
				pos_d   = pos_inc;
				shift_d = word;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == cfd_pkg::FIELD_LAST) begin
					cnt_d   = '0;
					shift_d = '0;
					if (phase_q == cfd_pkg::PH_LEN) begin
						if (bad_len) begin
							nres_valid         = 1'b1;
							nres.status        = cfd_pkg::ST_BAD_LENGTH;
							nres.last_in_frame = 1'b1;
							phase_d            = cfd_pkg::PH_HUNT;
							pos_d              = '0;
						end else begin
							flen_d  = word[cfd_pkg::LEN_W-1:0];
							phase_d = cfd_pkg::PH_SEQ;
						end
					end else begin
						seq_d = word;
						if (flen_q == cfd_pkg::HEADER_BYTES) begin
							nres_valid         = 1'b1;
							nres.status        = cfd_pkg::ST_EMPTY;
							nres.sequence_res  = word;
							nres.last_in_frame = 1'b1;
							phase_d            = cfd_pkg::PH_HUNT;
							pos_d              = '0;
						end else begin
							phase_d = cfd_pkg::PH_CMD;
						end
					end
				end
			end
			cfd_pkg::PH_CMD: begin
				pos_d   = pos_inc;
				cmd_d   = byte_s1;
				phase_d = cfd_pkg::PH_TYPE;
			end
			cfd_pkg::PH_TYPE: begin
				pos_d   = pos_inc;
				type_d  = byte_s1;
				shift_d = '0;
				cnt_d   = '0;
				if (byte_s1 == byte_type_q || byte_s1 == word_type_q) begin
					phase_d = cfd_pkg::PH_DATA;
				end else begin
					nres_valid         = 1'b1;
					nres.status        = cfd_pkg::ST_BAD_TYPE;
					nres.command       = cmd_q;
					nres.sub_type      = byte_s1;
					nres.sequence_res  = seq_q;
					nres.last_in_frame = 1'b1;
					phase_d            = cfd_pkg::PH_HUNT;
					pos_d              = '0;
				end
			end
			default: begin
				pos_d   = pos_inc;
				shift_d = word;
				cnt_d   = cnt_q + 1'b1;
				if (done) begin
					nres_valid         = 1'b1;
					nres.status        = cfd_pkg::ST_SUBFRAME;
					nres.command       = cmd_q;
					nres.sub_type      = type_q;
					nres.payload       = word;
					nres.sequence_res  = seq_q;
					nres.last_in_frame = last;
					shift_d            = '0;
					cnt_d              = '0;
					if (last) begin
						phase_d = cfd_pkg::PH_HUNT;
						pos_d   = '0;
					end else begin
						phase_d = cfd_pkg::PH_CMD;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfd_pkg::PH_HUNT;
			shift_q <= '0;
			cnt_q   <= '0;
			pos_q   <= '0;
			flen_q  <= '0;
			seq_q   <= '0;
			cmd_q   <= '0;
			type_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			shift_q <= shift_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			flen_q  <= flen_d;
			seq_q   <= seq_d;
			cmd_q   <= cmd_d;
			type_q  <= type_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= nres_valid;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && nres_valid) begin
			res_q <= nres;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = res_q.status;
	assign res.command       = res_q.command;
	assign res.sub_type      = res_q.sub_type;
	assign res.payload       = res_q.payload;
	assign res.sequence_res  = res_q.sequence_res;
	assign res.last_in_frame = res_q.last_in_frame;

	a_error_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		adv && nres_valid && nres.status != cfd_pkg::ST_SUBFRAME
		|=> phase_q == cfd_pkg::PH_HUNT && pos_q == '0)
		else $error("error or empty result did not return to hunting");

	a_bad_len_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == cfd_pkg::ST_BAD_LENGTH
		|-> res_q.sequence_res == '0 && res_q.last_in_frame && res_q.payload == '0)
		else $error("bad length result carries stale fields");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == cfd_pkg::PH_CMD || phase_q == cfd_pkg::PH_TYPE
			|| phase_q == cfd_pkg::PH_DATA)
		|-> pos_q < {1'b0, flen_q} + 12'd5)
		else $error("byte position ran past frame length");

	a_no_result_loss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> res_valid_q && $stable(res_q))
		else $error("pending result dropped or changed");

endmodule
